@@ src/npcq_pkg.sv @@
// Package for the nearest palette colour quantizer.
// Holds the function and register codes, configuration widths and reset values.
// Has no dependencies of its own.
package npcq_pkg;

    // Item function codes on the input channel.
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_PIXEL = 1'b1;

    // Configuration port.
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 5;
    localparam int NUM_COLORS_W   = 5;
    localparam int NUM_CHANNELS_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLORS   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_CHANNELS = 1'd1;

    localparam logic [NUM_COLORS_W-1:0]   NUM_COLORS_RESET   = 5'd16;
    localparam logic [NUM_CHANNELS_W-1:0] NUM_CHANNELS_RESET = 3'd3;

    // Channel fields present on each channel of the ports.
    localparam int PORT_CHANS = 4;

    // Defaults for the top level parameters.
    localparam int DEF_MAX_COLORS   = 16;
    localparam int DEF_MAX_CHANNELS = 4;
    localparam int DEF_SAMPLE_BITS  = 16;

endpackage

@@ src/nearest_palette_color_quantizer.sv @@
// Top level of the nearest palette colour quantizer: palette store, distance
// pipeline and registered comparison tree in one module.
// Depends on npcq_pkg.
//
// Usage. Items arrive on the s_ channel (valid/ready). A beat with s_func at
// FUNC_LOAD writes palette entry s_entry_index with the four channel fields and
// gives no result; it is written at the edge that accepts it. A beat with
// s_func at FUNC_PIXEL gives one m_ beat: the index of the nearest of the
// first num_colors entries by squared distance over the first num_channels
// channels (lowest index on a tie), that entry's channels (zero where unused)
// and a copy of s_last_pixel. num_colors and num_channels must be set through
// the write port only while the block is idle; the block does not check this.
// Timing. One item is accepted per cycle while s_ready is high. A pixel's result
// passes through one stage of differences, one of squares, one of channel sums,
// one per level of the comparison tree and the output register. The tree depth
// sets the latency.
// Reset clears the pipeline valid bits and sets num_colors to 16 and
// num_channels to 3; palette contents are undefined until loaded.
// When the receiver stalls, each stage holds its beat, empty stages still fill,
// and s_ready falls only once every stage ahead is occupied.
module nearest_palette_color_quantizer #(
    parameter int MAX_COLORS   = npcq_pkg::DEF_MAX_COLORS,
    parameter int MAX_CHANNELS = npcq_pkg::DEF_MAX_CHANNELS,
    parameter int SAMPLE_BITS  = npcq_pkg::DEF_SAMPLE_BITS,
    localparam int IDX_W       = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,

    input  logic                                   cfg_wr_en,
    input  logic [npcq_pkg::CFG_IDX_W-1:0]         cfg_addr,
    input  logic [npcq_pkg::CFG_DATA_W-1:0]        cfg_wr_data,

    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic                                   s_func,
    input  logic [IDX_W-1:0]                       s_entry_index,
    input  logic signed [SAMPLE_BITS-1:0]          s_chan_a,
    input  logic signed [SAMPLE_BITS-1:0]          s_chan_b,
    input  logic signed [SAMPLE_BITS-1:0]          s_chan_c,
    input  logic signed [SAMPLE_BITS-1:0]          s_chan_d,
    input  logic                                   s_last_pixel,

    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [IDX_W-1:0]                       m_color_index,
    output logic signed [SAMPLE_BITS-1:0]          m_out_a,
    output logic signed [SAMPLE_BITS-1:0]          m_out_b,
    output logic signed [SAMPLE_BITS-1:0]          m_out_c,
    output logic signed [SAMPLE_BITS-1:0]          m_out_d,
    output logic                                   m_last_out
);

    localparam int PCH    = npcq_pkg::PORT_CHANS;
    localparam int LV     = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 0;
    localparam int NLEAF  = 1 << LV;
    localparam int NNODE  = 2 * NLEAF - 1;
    localparam int USE_CH = (MAX_CHANNELS < PCH) ? MAX_CHANNELS : PCH;
    localparam int DIF_W  = SAMPLE_BITS + 1;
    localparam int SQ_W   = 2 * SAMPLE_BITS + 1;
    localparam int DIST_W = SQ_W + $clog2(MAX_CHANNELS);
    localparam int NPIPE  = 3 + LV;

    // Depth of a node in the heap-ordered comparison tree, root at zero.
    function automatic int heap_depth(input int n);
        int m;
        int d;
        m = n;
        d = 0;
        for (int i = 0; i < 16; i++) begin
            if (m > 0) begin
                m = (m - 1) >> 1;
                d = d + 1;
            end
        end
        return d;
    endfunction

    typedef struct packed {
        logic                              ok;
        logic [IDX_W-1:0]                  idx;
        logic [DIST_W-1:0]                 sqsum;
        logic [USE_CH-1:0][DIF_W-1:0]      dif;
    } node_t;

    typedef struct packed {
        logic [USE_CH-1:0][SAMPLE_BITS-1:0] px;
        logic [USE_CH-1:0]                  chan_on;
        logic                               last;
    } side_t;

    // ---------------------------------------------------------------------
    // Configuration
    // ---------------------------------------------------------------------
    logic [npcq_pkg::NUM_COLORS_W-1:0]   num_colors_reg;
    logic [npcq_pkg::NUM_CHANNELS_W-1:0] num_channels_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_colors_reg   <= npcq_pkg::NUM_COLORS_RESET;
            num_channels_reg <= npcq_pkg::NUM_CHANNELS_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                npcq_pkg::REG_NUM_COLORS: begin
                    num_colors_reg <= cfg_wr_data[npcq_pkg::NUM_COLORS_W-1:0];
                end
                npcq_pkg::REG_NUM_CHANNELS: begin
                    num_channels_reg <= cfg_wr_data[npcq_pkg::NUM_CHANNELS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Handshake and stage advance
    // ---------------------------------------------------------------------
    logic [NPIPE-1:0] vld_reg;
    logic             out_vld_reg;
    logic [NPIPE:0]   adv;
    logic             in_acc;
    logic             load_acc;
    logic             pix_acc;

    always_comb begin
        adv[NPIPE] = !out_vld_reg || m_ready;
        for (int i = NPIPE - 1; i >= 0; i--) begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign s_ready  = adv[0];
    assign in_acc   = s_valid && s_ready;
    assign load_acc = in_acc && (s_func == npcq_pkg::FUNC_LOAD);
    assign pix_acc  = in_acc && (s_func == npcq_pkg::FUNC_PIXEL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            if (adv[0]) begin
                vld_reg[0] <= pix_acc;
            end
            for (int i = 1; i < NPIPE; i++) begin
                if (adv[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
            if (adv[NPIPE]) begin
                out_vld_reg <= vld_reg[NPIPE-1];
            end
        end
    end

    // ---------------------------------------------------------------------
    // Input channels and palette store
    // ---------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] in_px   [PCH];
    logic signed [SAMPLE_BITS-1:0] pix_ext [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0]       chan_on_in;
    logic [MAX_COLORS-1:0]         ent_on;
    logic [SAMPLE_BITS-1:0]        palette_reg [MAX_COLORS][MAX_CHANNELS];

    assign in_px[0] = s_chan_a;
    assign in_px[1] = s_chan_b;
    assign in_px[2] = s_chan_c;
    assign in_px[3] = s_chan_d;

    for (genvar k = 0; k < MAX_CHANNELS; k++) begin : g_pix
        if (k < USE_CH) begin : g_used
            assign pix_ext[k] = in_px[k];
        end else begin : g_none
            assign pix_ext[k] = '0;
        end
        assign chan_on_in[k] = int'(num_channels_reg) > k;
    end

    // Entry zero is always searched, so a count of zero behaves as one.
    for (genvar p = 0; p < MAX_COLORS; p++) begin : g_ent
        assign ent_on[p] = (p == 0) || (int'(num_colors_reg) > p);
    end

    always_ff @(posedge aclk) begin
        if (load_acc && (int'(s_entry_index) < MAX_COLORS)) begin
            for (int k = 0; k < MAX_CHANNELS; k++) begin
                palette_reg[s_entry_index][k] <= pix_ext[k];
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stage 0: channel differences; stage 1: squares
    // ---------------------------------------------------------------------
    logic signed [DIF_W-1:0] dif0_next [MAX_COLORS][MAX_CHANNELS];
    logic signed [DIF_W-1:0] dif0_reg  [MAX_COLORS][MAX_CHANNELS];
    logic [MAX_COLORS-1:0]   on0_reg;
    logic [SQ_W-1:0]         sq1_next  [MAX_COLORS][MAX_CHANNELS];
    logic [SQ_W-1:0]         sq1_reg   [MAX_COLORS][MAX_CHANNELS];
    logic signed [DIF_W-1:0] dif1_reg  [MAX_COLORS][USE_CH];
    logic [MAX_COLORS-1:0]   on1_reg;
    side_t                   side_next;
    side_t                   side_reg  [NPIPE];

    // Unused channels get a zero difference so they add nothing to the distance.
    always_comb begin
        logic [SAMPLE_BITS-1:0] pc;
        for (int p = 0; p < MAX_COLORS; p++) begin
            for (int k = 0; k < MAX_CHANNELS; k++) begin
                pc = palette_reg[p][k];
                if (chan_on_in[k]) begin
                    dif0_next[p][k] = $signed({pix_ext[k][SAMPLE_BITS-1], pix_ext[k]})
                                    - $signed({pc[SAMPLE_BITS-1], pc});
                end else begin
                    dif0_next[p][k] = '0;
                end
            end
        end
    end

    always_comb begin
        logic signed [2*DIF_W-1:0] prod;
        for (int p = 0; p < MAX_COLORS; p++) begin
            for (int k = 0; k < MAX_CHANNELS; k++) begin
                prod = dif0_reg[p][k] * dif0_reg[p][k];
                sq1_next[p][k] = prod[SQ_W-1:0];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < USE_CH; k++) begin
            side_next.px[k]      = pix_ext[k];
            side_next.chan_on[k] = chan_on_in[k];
        end
        side_next.last = s_last_pixel;
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            dif0_reg    <= dif0_next;
            on0_reg     <= ent_on;
            side_reg[0] <= side_next;
        end
        if (adv[1]) begin
            sq1_reg <= sq1_next;
            on1_reg <= on0_reg;
            for (int p = 0; p < MAX_COLORS; p++) begin
                for (int k = 0; k < USE_CH; k++) begin
                    dif1_reg[p][k] <= dif0_reg[p][k];
                end
            end
        end
        for (int i = 1; i < NPIPE; i++) begin
            if (adv[i]) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stage 2: channel sums into the leaves; then one tree level per stage
    // ---------------------------------------------------------------------
    node_t node_next [NNODE];
    node_t node_reg  [NNODE];

    for (genvar n = 0; n < NNODE; n++) begin : g_node
        localparam int D  = heap_depth(n);
        localparam int ST = 2 + LV - D;

        if (D == LV) begin : g_leaf
            localparam int P = n - (NLEAF - 1);
            if (P < MAX_COLORS) begin : g_real
                always_comb begin
                    logic [DIST_W-1:0] acc;
                    acc = '0;
                    for (int k = 0; k < MAX_CHANNELS; k++) begin
                        acc = acc + DIST_W'(sq1_reg[P][k]);
                    end
                    node_next[n].ok    = on1_reg[P];
                    node_next[n].idx   = IDX_W'(P);
                    node_next[n].sqsum = acc;
                    for (int k = 0; k < USE_CH; k++) begin
                        node_next[n].dif[k] = dif1_reg[P][k];
                    end
                end
            end else begin : g_pad
                // Padding leaf beyond the palette never wins.
                assign node_next[n] = '0;
            end
        end else begin : g_cmp
            logic take_r;
            // The right child wins only when strictly nearer, so ties keep the
            // lower index on the left.
            assign take_r = node_reg[2*n+2].ok
                         && (!node_reg[2*n+1].ok
                             || (node_reg[2*n+2].sqsum < node_reg[2*n+1].sqsum));
            assign node_next[n] = take_r ? node_reg[2*n+2] : node_reg[2*n+1];
        end

        always_ff @(posedge aclk) begin
            if (adv[ST]) begin
                node_reg[n] <= node_next[n];
            end
        end
    end

    // ---------------------------------------------------------------------
    // Output register: the chosen colour is rebuilt as pixel minus difference
    // ---------------------------------------------------------------------
    logic [IDX_W-1:0]       out_idx_reg;
    logic [SAMPLE_BITS-1:0] out_ch_reg [PCH];
    logic                   out_last_reg;

    always_ff @(posedge aclk) begin
        if (adv[NPIPE]) begin
            out_idx_reg  <= node_reg[0].idx;
            out_last_reg <= side_reg[NPIPE-1].last;
        end
    end

    for (genvar k = 0; k < PCH; k++) begin : g_out
        if (k < USE_CH) begin : g_used
            logic [SAMPLE_BITS-1:0] px;
            logic [DIF_W-1:0]       pc_full;
            assign px      = side_reg[NPIPE-1].px[k];
            assign pc_full = $signed({px[SAMPLE_BITS-1], px})
                           - $signed(node_reg[0].dif[k]);
            always_ff @(posedge aclk) begin
                if (adv[NPIPE]) begin
                    out_ch_reg[k] <= side_reg[NPIPE-1].chan_on[k]
                                   ? pc_full[SAMPLE_BITS-1:0] : '0;
                end
            end
        end else begin : g_none
            always_ff @(posedge aclk) begin
                out_ch_reg[k] <= '0;
            end
        end
    end

    assign m_valid       = out_vld_reg;
    assign m_color_index = out_idx_reg;
    assign m_out_a       = out_ch_reg[0];
    assign m_out_b       = out_ch_reg[1];
    assign m_out_c       = out_ch_reg[2];
    assign m_out_d       = out_ch_reg[3];
    assign m_last_out    = out_last_reg;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_index_in_palette: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg |-> (int'(out_idx_reg) < MAX_COLORS))
        else $error("chosen index lies beyond the palette");

    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        load_acc |=> !vld_reg[0])
        else $error("palette load entered the distance pipeline");

    a_root_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[NPIPE-1] && !adv[NPIPE-1]) |=> (vld_reg[NPIPE-1] && $stable(node_reg[0])))
        else $error("tree root changed while stalled");

    a_out_from_root: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_vld_reg) |-> $past(vld_reg[NPIPE-1]))
        else $error("result appeared without a beat at the tree root");

endmodule
